// ===== rtl/wwss_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted work-slot selector package
// Transaction types and scoring constants shared by the interfaces and the
// selector.
// ----------------------------------------------------------------------------
package wwss_pkg;

  localparam int unsigned NumSlots = 64;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned ScoreW = 20;
  // Wide enough for the exact, unsaturated score of any descriptor.
  localparam int unsigned RawW   = 22;

  localparam int signed DepthWeight  = 16;
  localparam int signed WorkerWeight = 6400;
  localparam int signed NestWeight   = 200;
  localparam int signed PlyWeight    = 2;
  localparam int signed CheckPenalty = 80;
  localparam int signed ProgBonus    = 90000;

  localparam int signed ScoreMin = -(2 ** (ScoreW - 1));
  localparam int signed ScoreMax = (2 ** (ScoreW - 1)) - 1;

  typedef enum logic [1:0] {
    KIND_0  = 2'd0,
    KIND_1  = 2'd1,
    KIND_PV = 2'd2,
    KIND_3  = 2'd3
  } node_kind_e;

  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic             is_open;
    logic             has_moves;
    logic [6:0]       worker_count;
    logic [3:0]       nest_level;
    logic [6:0]       search_depth;
    logic [6:0]       search_ply;
    logic             king_checked;
    logic [1:0]       node_kind;
    logic [7:0]       move_cursor;
    logic             last;
  } slot_item_t;

  typedef struct packed {
    logic                     found;
    logic [SlotW-1:0]         best_slot;
    logic signed [ScoreW-1:0] best_score;
  } result_item_t;

endpackage

// ===== rtl/wwss_if.sv =====
// ----------------------------------------------------------------------------
// Weighted work-slot selector channels
// Valid/ready channels for slot descriptors and for selection results.
// ----------------------------------------------------------------------------
interface wwss_slot_if;
  import wwss_pkg::*;

  logic       valid;
  logic       ready;
  slot_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wwss_result_if;
  import wwss_pkg::*;

  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/weighted_work_slot_selector_top.sv =====
// ----------------------------------------------------------------------------
// A descriptor marked last passes from the input register through the score
// and compare into the result register, from which its result transaction
// takes place. Throughput: one descriptor per cycle, set by the combinational
// score and compare against the running best; only a last descriptor waits,
// while the previous result has not been taken.
// Reset (rst_ni low, async) empties both registers and clears the running best.
// ----------------------------------------------------------------------------
// Weighted work-slot selector
// Scores each eligible work-slot descriptor of a scan and reports the best
// slot when the last descriptor of the scan has been taken.
// ----------------------------------------------------------------------------
module weighted_work_slot_selector_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  wwss_slot_if.sink     slot_in_i,
  wwss_result_if.source result_o
);
  import wwss_pkg::*;

  // Input register stage. Descriptors land here before they are scored.
  logic       in_valid_q;
  slot_item_t in_q;

  // Running best of the scan in progress.
  logic                     any_found_q, any_found_d;
  logic [SlotW-1:0]         best_pos_q, best_pos_d;
  logic signed [ScoreW-1:0] best_val_q, best_val_d;

  // Result register, which parts the output side from the scoring stage.
  logic         out_valid_q, out_valid_d;
  result_item_t out_q, out_d;

  logic stage_fire;
  logic in_fire;

  // The staged descriptor retires unless it is the last of a scan and the
  // result register still holds a result that has not been taken.
  assign stage_fire = in_valid_q &&
                      (!in_q.last || !out_valid_q || result_o.ready);
  assign slot_in_i.ready = !in_valid_q || stage_fire;
  assign in_fire = slot_in_i.valid && slot_in_i.ready;

  // --------------------------------------------------------------------------
  // Score of the staged descriptor. All weights are constants, so the
  // products reduce to shifts and adds.
  // --------------------------------------------------------------------------
  logic signed [RawW-1:0] raw_score;
  logic signed [ScoreW-1:0] sat_score;
  logic [8:0] workers_ext;
  logic [8:0] next_ext;
  logic bonus;
  logic eligible;
  logic take;

  always_comb begin
    workers_ext = {2'b00, in_q.worker_count};
    next_ext    = {1'b0, in_q.move_cursor};
    // The progress bonus needs a node of the principal kind whose next move
    // lies strictly between workers+1 and workers+5.
    bonus = (node_kind_e'(in_q.node_kind) == KIND_PV) &&
            (next_ext > (workers_ext + 9'd1)) &&
            (next_ext < (workers_ext + 9'd5));

    raw_score = RawW'(DepthWeight) * $signed({{(RawW-7){1'b0}}, in_q.search_depth})
              - RawW'(WorkerWeight) * $signed({{(RawW-7){1'b0}}, in_q.worker_count})
              - RawW'(NestWeight) * $signed({{(RawW-4){1'b0}}, in_q.nest_level})
              - RawW'(PlyWeight) * $signed({{(RawW-7){1'b0}}, in_q.search_ply});
    if (in_q.king_checked) begin
      raw_score = raw_score - RawW'(CheckPenalty);
    end
    if (bonus) begin
      raw_score = raw_score + RawW'(ProgBonus);
    end

    // Saturate to the signed result width; only heavily loaded slots can
    // fall below the range.
    if (raw_score < $signed(RawW'(ScoreMin))) begin
      sat_score = ScoreW'(ScoreMin);
    end else if (raw_score > $signed(RawW'(ScoreMax))) begin
      sat_score = ScoreW'(ScoreMax);
    end else begin
      sat_score = raw_score[ScoreW-1:0];
    end
  end

  // A slot index outside the configured slot count is ignored.
  assign eligible = in_q.is_open && in_q.has_moves &&
                    ({1'b0, in_q.slot_index} < (SlotW+1)'(NumSlots));
  // Strictly greater, so the earliest of equal scores is kept.
  assign take = eligible && (!any_found_q || (sat_score > best_val_q));

  // --------------------------------------------------------------------------
  // Running best update and result formation.
  // --------------------------------------------------------------------------
  always_comb begin
    any_found_d = any_found_q;
    best_pos_d  = best_pos_q;
    best_val_d  = best_val_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (stage_fire) begin
      if (take) begin
        any_found_d = 1'b1;
        best_pos_d  = in_q.slot_index;
        best_val_d  = sat_score;
      end
      if (in_q.last) begin
        out_valid_d = 1'b1;
        if (any_found_d) begin
          out_d.found      = 1'b1;
          out_d.best_slot  = best_pos_d;
          out_d.best_score = best_val_d;
        end else begin
          out_d = '0;
        end
        // The scan is closed: start the next one afresh.
        any_found_d = 1'b0;
        best_pos_d  = '0;
        best_val_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      any_found_q <= 1'b0;
      best_pos_q  <= '0;
      best_val_q  <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (stage_fire) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      any_found_q <= any_found_d;
      best_pos_q  <= best_pos_d;
      best_val_q  <= best_val_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= slot_in_i.data;
    end
    out_q <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule
